FILE: rtl/gti_pkg.sv
package gti_pkg;

  // Table geometry and number format
  localparam int TableDepth = 4096;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int FracBits   = 16;
  localparam int CountW     = 13;
  localparam int FloorW     = 64 - 2 * FracBits;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DIMS_MODE  = 3'd0,
    CFG_COUNT_X    = 3'd1,
    CFG_COUNT_Y    = 3'd2,
    CFG_COUNT_Z    = 3'd3,
    CFG_INV_STEP_X = 3'd4,
    CFG_INV_STEP_Y = 3'd5,
    CFG_INV_STEP_Z = 3'd6
  } cfg_idx_e;

  // Per-axis cell selection
  typedef struct packed {
    logic [CountW-1:0] idx;
    logic signed [31:0] weight;
    logic              step;
    logic              clamp;
  } axis_t;

endpackage

FILE: rtl/grid_trilinear_interpolator_unit.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  req_type, table_addr, table_value, pos_x/y/z
// result    out        out_valid_o/out_stall_i interp_value, clamped
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// One request per cycle while the skid register is empty; a query result passes
// through 3 setup stages, a bank read, three 2-stage lerps and the output register.
// Latency is set by the 64-bit axis products and the chained lerp multipliers.
// Eight table copies give the eight corner reads of a query in the same cycle.
// Reset clears valid bits and sets config to defaults; the table is undefined until loaded.
// A stalled result parks in a skid register; the pipe halts only while it is full.
module grid_trilinear_interpolator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [11:0]         table_addr_i,
  input  logic signed [31:0]  table_value_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  interp_value_o,
  output logic                clamped_o
);
  import gti_pkg::*;

  // ---------------- configuration registers ----------------
  logic [1:0]        dims_q;
  logic [CountW-1:0] cnt_x_q, cnt_y_q, cnt_z_q;
  logic [31:0]       inv_x_q, inv_y_q, inv_z_q;
  logic [AddrW-1:0]  plane_q;   // count_x * count_y, wrapped to the table

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= 2'd3;
      cnt_x_q <= CountW'(2);
      cnt_y_q <= CountW'(2);
      cnt_z_q <= CountW'(2);
      inv_x_q <= 32'(1) << FracBits;
      inv_y_q <= 32'(1) << FracBits;
      inv_z_q <= 32'(1) << FracBits;
      plane_q <= AddrW'(4);
    end else begin
      plane_q <= AddrW'(cnt_x_q * cnt_y_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIMS_MODE:  dims_q  <= cfg_data_i[1:0];
          CFG_COUNT_X:    cnt_x_q <= cfg_data_i[CountW-1:0];
          CFG_COUNT_Y:    cnt_y_q <= cfg_data_i[CountW-1:0];
          CFG_COUNT_Z:    cnt_z_q <= cfg_data_i[CountW-1:0];
          CFG_INV_STEP_X: inv_x_q <= cfg_data_i;
          CFG_INV_STEP_Y: inv_y_q <= cfg_data_i;
          CFG_INV_STEP_Z: inv_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------- flow control ----------------
  logic skid_valid_q;
  logic adv;
  logic take_in;

  // advance every stage while the skid register is empty
  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign take_in    = in_valid_i && adv;

  // ---------------- stage 1: scaled coordinates ----------------
  logic               v1_q, q1_q;
  logic [11:0]        addr1_q;
  logic [31:0]        val1_q;
  logic signed [63:0] tx1_q, ty1_q, tz1_q;
  logic signed [64:0] px, py, pz;

  always_comb begin
    px = 65'(pos_x_i) * $signed({33'b0, inv_x_q});
    py = 65'(pos_y_i) * $signed({33'b0, inv_y_q});
    pz = 65'(pos_z_i) * $signed({33'b0, inv_z_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= take_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q1_q    <= req_type_i;
      addr1_q <= table_addr_i;
      val1_q  <= table_value_i;
      tx1_q   <= px[63:0];
      ty1_q   <= py[63:0];
      tz1_q   <= pz[63:0];
    end
  end

  // ---------------- stage 2: cell index and weights ----------------
  logic   three;
  axis_t  ax_d, ay_d, az_d;
  logic   v2_q, q2_q;
  logic [11:0] addr2_q;
  logic [31:0] val2_q;
  axis_t  ax2_q, ay2_q, az2_q;

  // dims_mode 2 is bilinear; anything else runs all three axes
  assign three = (dims_q != 2'd2);

  gti_axis u_axis_x (.t_i(tx1_q), .count_i(cnt_x_q), .used_i(1'b1),  .axis_o(ax_d));
  gti_axis u_axis_y (.t_i(ty1_q), .count_i(cnt_y_q), .used_i(1'b1),  .axis_o(ay_d));
  gti_axis u_axis_z (.t_i(tz1_q), .count_i(cnt_z_q), .used_i(three), .axis_o(az_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q2_q    <= q1_q;
      addr2_q <= addr1_q;
      val2_q  <= val1_q;
      ax2_q   <= ax_d;
      ay2_q   <= ay_d;
      az2_q   <= az_d;
    end
  end

  // ---------------- stage 3: address terms ----------------
  logic v3_q, q3_q;
  logic [11:0] addr3_q;
  logic [31:0] val3_q;
  logic [AddrW-1:0] base3_q, ox3_q, oy3_q, oz3_q;
  logic signed [31:0] wx3_q, wy3_q, wz3_q;
  logic cl3_q;
  logic [AddrW-1:0] row_d, pln_d, sy;

  always_comb begin
    sy    = AddrW'(cnt_x_q);
    row_d = AddrW'(sy * AddrW'(ay2_q.idx));
    pln_d = AddrW'(plane_q * AddrW'(az2_q.idx));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q3_q    <= q2_q;
      addr3_q <= addr2_q;
      val3_q  <= val2_q;
      base3_q <= AddrW'(ax2_q.idx) + row_d + pln_d;
      ox3_q   <= ax2_q.step ? AddrW'(1) : '0;
      oy3_q   <= ay2_q.step ? sy : '0;
      oz3_q   <= az2_q.step ? plane_q : '0;
      wx3_q   <= ax2_q.weight;
      wy3_q   <= ay2_q.weight;
      wz3_q   <= az2_q.weight;
      cl3_q   <= ax2_q.clamp || ay2_q.clamp || az2_q.clamp;
    end
  end

  // ---------------- stage 4: corner reads and table loads ----------------
  // Loads write here, in order with the reads of earlier queries.
  logic              we;
  logic [AddrW-1:0]  raddr [8];
  logic [31:0]       rdata [8];
  logic              v4_q, cl4_q;
  logic signed [31:0] wx4_q, wy4_q, wz4_q;

  assign we = adv && v3_q && !q3_q && ({20'b0, addr3_q} < 32'(TableDepth));

  for (genvar k = 0; k < 8; k++) begin : g_bank
    assign raddr[k] = base3_q + (k[0] ? ox3_q : '0) + (k[1] ? oy3_q : '0)
                    + (k[2] ? oz3_q : '0);
    gti_bank u_bank (
      .clk_i   (clk_i),
      .en_i    (adv),
      .we_i    (we),
      .waddr_i (AddrW'(addr3_q)),
      .wdata_i (val3_q),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q && q3_q;   // drop loads, they give no result
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cl4_q <= cl3_q;
      wx4_q <= wx3_q;
      wy4_q <= wy3_q;
      wz4_q <= wz3_q;
    end
  end

  // ---------------- stages 5-10: lerps along x, y, z ----------------
  logic signed [31:0] c00, c10, c01, c11, r0, r1, vz;
  logic               vp_q [6];
  logic               clp_q [6];
  logic signed [31:0] wyp_q [2];
  logic signed [31:0] wzp_q [4];

  gti_lerp u_lx0 (.clk_i, .en_i(adv), .lo_i(rdata[0]), .hi_i(rdata[1]), .w_i(wx4_q), .r_o(c00));
  gti_lerp u_lx1 (.clk_i, .en_i(adv), .lo_i(rdata[2]), .hi_i(rdata[3]), .w_i(wx4_q), .r_o(c10));
  gti_lerp u_lx2 (.clk_i, .en_i(adv), .lo_i(rdata[4]), .hi_i(rdata[5]), .w_i(wx4_q), .r_o(c01));
  gti_lerp u_lx3 (.clk_i, .en_i(adv), .lo_i(rdata[6]), .hi_i(rdata[7]), .w_i(wx4_q), .r_o(c11));
  gti_lerp u_ly0 (.clk_i, .en_i(adv), .lo_i(c00), .hi_i(c10), .w_i(wyp_q[1]), .r_o(r0));
  gti_lerp u_ly1 (.clk_i, .en_i(adv), .lo_i(c01), .hi_i(c11), .w_i(wyp_q[1]), .r_o(r1));
  // in 2-D the z weight is zero and r0 passes through
  gti_lerp u_lz  (.clk_i, .en_i(adv), .lo_i(r0), .hi_i(r1), .w_i(wzp_q[3]), .r_o(vz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) vp_q[i] <= 1'b0;
    end else if (adv) begin
      vp_q[0] <= v4_q;
      for (int i = 1; i < 6; i++) vp_q[i] <= vp_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clp_q[0] <= cl4_q;
      for (int i = 1; i < 6; i++) clp_q[i] <= clp_q[i-1];
      wyp_q[0] <= wy4_q;
      wyp_q[1] <= wyp_q[0];
      wzp_q[0] <= wz4_q;
      for (int i = 1; i < 4; i++) wzp_q[i] <= wzp_q[i-1];
    end
  end

  // ---------------- output register and skid ----------------
  logic               out_valid_q;
  logic signed [31:0] out_val_q, skid_val_q;
  logic               out_cl_q, skid_cl_q;
  logic               out_take;

  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (vp_q[5]) begin
      if (out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;   // hold the result behind the stalled one
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_val_q <= skid_val_q;
        out_cl_q  <= skid_cl_q;
      end
    end else if (vp_q[5]) begin
      if (out_take) begin
        out_val_q <= vz;
        out_cl_q  <= clp_q[5];
      end else begin
        skid_val_q <= vz;
        skid_cl_q  <= clp_q[5];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_val_q;
  assign clamped_o      = out_cl_q;

endmodule

FILE: rtl/gti_bank.sv
module gti_bank (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      we_i,
  input  logic [gti_pkg::AddrW-1:0] waddr_i,
  input  logic [31:0]               wdata_i,
  input  logic [gti_pkg::AddrW-1:0] raddr_i,
  output logic [31:0]               rdata_o
);
  import gti_pkg::*;

  logic [31:0] mem_q [TableDepth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gti_axis.sv
module gti_axis (
  input  logic signed [63:0]         t_i,
  input  logic [gti_pkg::CountW-1:0] count_i,
  input  logic                       used_i,
  output gti_pkg::axis_t             axis_o
);
  import gti_pkg::*;

  logic [CountW-1:0]  last;
  logic [FloorW-1:0]  fl;
  logic               neg;
  logic               big;
  logic [CountW-1:0]  idx;
  logic signed [63:0] ws;

  always_comb begin
    last = (count_i == '0) ? '0 : count_i - CountW'(1);
    neg  = t_i[63];
    fl   = t_i[63:2*FracBits];
    big  = !neg && (fl > FloorW'(last));
    idx  = neg ? '0 : (big ? last : fl[CountW-1:0]);
    ws   = t_i >>> FracBits;
    axis_o = '0;
    if (used_i) begin
      axis_o.idx   = idx;
      axis_o.clamp = neg || big;
      if (idx == last) begin
        axis_o.weight = '0;
        axis_o.step   = 1'b0;
      end else if (neg) begin
        axis_o.weight = (ws < -64'sd2147483648) ? 32'sh80000000 : ws[31:0];
        axis_o.step   = 1'b1;
      end else begin
        axis_o.weight = $signed({{(32-FracBits){1'b0}}, t_i[2*FracBits-1:FracBits]});
        axis_o.step   = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/gti_lerp.sv
module gti_lerp (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  input  logic signed [31:0] w_i,
  output logic signed [31:0] r_o
);
  import gti_pkg::*;

  logic signed [32:0] diff;
  logic signed [64:0] prod;
  logic signed [63:0] p_q, p_d;
  logic signed [31:0] lo_q;
  logic signed [63:0] sum;
  logic signed [31:0] r_q, r_d;

  always_comb begin
    diff = $signed({hi_i[31], hi_i}) - $signed({lo_i[31], lo_i});
    prod = 65'(diff) * 65'(w_i);
    p_d  = prod[63:0];
    sum  = (p_q >>> FracBits) + 64'(lo_q);
    if (sum > 64'sd2147483647) begin
      r_d = 32'sh7FFFFFFF;
    end else if (sum < -64'sd2147483648) begin
      r_d = 32'sh80000000;
    end else begin
      r_d = sum[31:0];
    end
  end

  // multiply, then shift, add and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= p_d;
      lo_q <= lo_i;
      r_q  <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

FILE: tb/testbench.sv
module testbench;
  import gti_pkg::*;

  // queries touch only this low part of the table, but for the largest-count directed ones
  localparam int FillDepth = 256;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [11:0]        table_addr_i = '0;
  logic signed [31:0] table_value_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] interp_value_o;
  logic               clamped_o;

  grid_trilinear_interpolator_unit u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct {
    logic [31:0] value;
    logic        clamp;
  } interp_t;

  typedef struct {
    longint idx;
    longint w;
    longint step;
    bit     clamp;
  } cell_sel_t;

  // shadow copy of the block's table and registers
  logic signed [31:0] shadow_table [TableDepth];
  logic [1:0]  dims_r;
  logic [12:0] cnt_x, cnt_y, cnt_z;
  logic [31:0] inv_x, inv_y, inv_z;

  interp_t pending_interp[$];
  int      mismatches = 0;
  bit      quiet = 1'b0;

  function automatic cell_sel_t pick_cell(logic signed [31:0] pos, logic [31:0] inv,
                                          logic [12:0] cnt);
    cell_sel_t c;
    longint last, t, fl;
    last = (cnt == 0) ? 0 : longint'(cnt) - 1;
    t = longint'(pos) * longint'({32'd0, inv});
    c.clamp = 1'b0;
    if (t < 0) begin
      c.idx = 0;
      c.clamp = 1'b1;
    end else begin
      fl = t >>> 32;
      c.clamp = fl > last;
      c.idx = c.clamp ? last : fl;
    end
    if (c.idx == last) begin
      c.w = 0;
      c.step = 0;
    end else if (t < 0) begin
      c.w = t >>> FracBits;
      if (c.w < -64'sd2147483648) c.w = -64'sd2147483648;
      c.step = 1;
    end else begin
      c.w = (t >>> FracBits) & 64'hFFFF;
      c.step = 1;
    end
    return c;
  endfunction

  function automatic longint blend(longint lo, longint hi, longint w);
    longint r;
    r = lo + (((hi - lo) * w) >>> FracBits);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint sample_at(longint a);
    return longint'(shadow_table[a[11:0]]);
  endfunction

  function automatic interp_t interpolate(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz);
    interp_t   r;
    cell_sel_t ax, ay, az;
    bit        three;
    longint    sy, sz, b, ox, oy, oz, c00, c10, c01, c11, r0, r1, v;
    three = dims_r != 2'd2;
    ax = pick_cell(px, inv_x, cnt_x);
    ay = pick_cell(py, inv_y, cnt_y);
    if (three) az = pick_cell(pz, inv_z, cnt_z);
    else az = '{0, 0, 0, 1'b0};
    sy = cnt_x;
    sz = longint'(cnt_x) * longint'(cnt_y);
    b  = ax.idx + sy * ay.idx + sz * az.idx;
    ox = ax.step;
    oy = ay.step * sy;
    oz = az.step * sz;
    c00 = blend(sample_at(b), sample_at(b + ox), ax.w);
    c10 = blend(sample_at(b + oy), sample_at(b + ox + oy), ax.w);
    r0  = blend(c00, c10, ay.w);
    if (three) begin
      c01 = blend(sample_at(b + oz), sample_at(b + ox + oz), ax.w);
      c11 = blend(sample_at(b + oy + oz), sample_at(b + ox + oy + oz), ax.w);
      r1  = blend(c01, c11, ay.w);
      v   = blend(r0, r1, az.w);
    end else begin
      v = r0;
    end
    r.value = v[31:0];
    r.clamp = ax.clamp | ay.clamp | az.clamp;
    return r;
  endfunction

  // Send one request; drive at the falling edge, judge the stall in the quiet
  // half of the low phase, and update the shadow state on acceptance.
  task automatic send_request(bit is_query, logic [11:0] addr, logic [31:0] val,
                              logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    bit stalled;
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = is_query;
    table_addr_i  = addr;
    table_value_i = val;
    pos_x_i = px;
    pos_y_i = py;
    pos_z_i = pz;
    do begin
      #2 stalled = in_stall_o;
      @(negedge clk_i);
    end while (stalled);
    if (is_query) pending_interp.push_back(interpolate(px, py, pz));
    else shadow_table[addr] = val;
    in_valid_i = 1'b0;
  endtask

  // Drain the pipe, let in-flight loads settle, then write one register.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    while (pending_interp.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_DIMS_MODE:  dims_r = data[1:0];
      CFG_COUNT_X:    cnt_x = data[12:0];
      CFG_COUNT_Y:    cnt_y = data[12:0];
      CFG_COUNT_Z:    cnt_z = data[12:0];
      CFG_INV_STEP_X: inv_x = data;
      CFG_INV_STEP_Y: inv_y = data;
      CFG_INV_STEP_Z: inv_z = data;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [1:0] d, logic [12:0] cx, logic [12:0] cy, logic [12:0] cz,
                          logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    write_reg(CFG_DIMS_MODE, 32'(d));
    write_reg(CFG_COUNT_X, 32'(cx));
    write_reg(CFG_COUNT_Y, 32'(cy));
    write_reg(CFG_COUNT_Z, 32'(cz));
    write_reg(CFG_INV_STEP_X, ix);
    write_reg(CFG_INV_STEP_Y, iy);
    write_reg(CFG_INV_STEP_Z, iz);
  endtask

  // Load the low part of the table; the random queries stay inside it.
  task automatic test_fill_table();
    logic [31:0] v;
    for (int a = 0; a < FillDepth; a++) begin
      v = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      send_request(1'b0, 12'(a), v, $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic test_directed();
    // default geometry: origin, inside the cell, far outside, below zero
    send_request(1'b1, 0, 0, 0, 0, 0);
    send_request(1'b1, 0, 0, 32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
    send_request(1'b1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(1'b1, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(1'b1, 0, 0, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000);
    // saturating lerps between the extreme sample values
    send_request(1'b0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    send_request(1'b0, 1, 32'h8000_0000, 0, 0, 0);
    send_request(1'b1, 0, 0, 32'hFFFE_0000, 0, 0);
    send_request(1'b1, 0, 0, 32'h8000_0000, 32'hFFFF_0000, 0);
    // bilinear, maximal inverse step, zero inverse step
    set_grid(2'd2, 13'd5, 13'd4, 13'd2, 32'hFFFF_FFFF, 32'd0, 32'd65536);
    send_request(1'b1, 0, 0, 32'd1, 32'h1234_5678, 32'h7FFF_FFFF);
    send_request(1'b1, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    // count below two, unused dims codes
    set_grid(2'd0, 13'd1, 13'd0, 13'd3, 32'd65536, 32'd65536, 32'd65536);
    send_request(1'b1, 0, 0, 0, 0, 32'h0001_8000);
    send_request(1'b1, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);
    // largest counts: row and plane terms wrap around the table
    set_grid(2'd1, 13'd4096, 13'd4096, 13'd4096, 32'd65536, 32'd65536, 32'd65536);
    send_request(1'b1, 0, 0, 32'h00FE_8000, 32'h0FFF_0000, 32'h0123_4567);
    send_request(1'b1, 0, 0, 32'h0005_4000, 32'h0003_2000, 32'h0002_1000);
    send_request(1'b1, 0, 0, 32'h00FE_0000, 32'h0100_0000, 32'h8000_0000);
  endtask

  // Count of at most lim samples.
  function automatic logic [12:0] rand_count(int lim);
    int c;
    case ($urandom_range(9))
      0: c = lim;
      1: c = $urandom_range(0, 1);
      2: c = $urandom_range(2, lim);
      default: c = $urandom_range(2, 9);
    endcase
    if (c > lim) c = lim;
    return 13'(c);
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3, 4: return $urandom_range(32'h0000_4000, 32'h0004_0000);
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Mostly points near the grid, some just below zero, the rest raw bit patterns.
  function automatic logic [31:0] rand_pos(logic [12:0] cnt);
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: return -$urandom_range(0, 32'h0002_0000);
      default: return $urandom_range(0, {3'd0, cnt, 16'd0});
    endcase
  endfunction

  // Grids hold at most FillDepth samples, so every corner read is loaded.
  task automatic test_random();
    logic [1:0]  d;
    logic [12:0] cx, cy, cz;
    int          fx, fxy;
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 3);
      d   = 2'($urandom_range(3));
      cx  = rand_count(FillDepth / 2);
      fx  = (cx == 0) ? 1 : int'(cx);
      cy  = rand_count(FillDepth / fx);
      fxy = fx * ((cy == 0) ? 1 : int'(cy));
      cz  = (d == 2'd2) ? rand_count(4096) : rand_count(FillDepth / fxy);
      set_grid(d, cx, cy, cz, rand_inv(), rand_inv(), rand_inv());
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(3) == 0)
          send_request(1'b0, 12'($urandom()), $urandom(), $urandom(), $urandom(),
                       $urandom());
        else
          send_request(1'b1, 12'($urandom()), $urandom(), rand_pos(cnt_x), rand_pos(cnt_y),
                       rand_pos(cnt_z));
      end
    end
    quiet = 1'b0;
  endtask

  // Result side: random stall, dropped during quiet stretches.
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 31);
  end

  always @(posedge clk_i) begin
    interp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_interp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h clamped %b", interp_value_o,
                                       clamped_o);
      end else begin
        want = pending_interp.pop_front();
        if (interp_value_o !== want.value || clamped_o !== want.clamp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b, got %h/%b", want.value, want.clamp,
                     interp_value_o, clamped_o);
        end
      end
    end
  end

  initial begin
    dims_r = 2'd3;
    cnt_x = 13'd2;
    cnt_y = 13'd2;
    cnt_z = 13'd2;
    inv_x = 32'h0001_0000;
    inv_y = 32'h0001_0000;
    inv_z = 32'h0001_0000;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_fill_table();
    test_directed();
    test_random();
    while (pending_interp.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (mismatches == 0 && pending_interp.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
